[src/stk_pkg.sv]
package stk_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;

  // Stream payload widths
  localparam int IN_TDATA_W  = VAL_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_BITS    = 1 + CNT_W + 2 * VAL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;
  localparam int OUT_TUSER_W = 2;

  // Operation codes carried in the slave tuser
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  // Status codes returned with every result
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POP_EMPTY   = 2'd1,
    ST_PUSH_FULL   = 2'd2,
    ST_CLEAR_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_t;

  // One result item, handed from the controller to the output register
  typedef struct packed {
    logic                    empty_res;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] min_value;
    status_t                 status;
  } res_t;

endpackage

[src/stk_ram.sv]
module stk_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/stk_ctrl.sv]
module stk_ctrl
  import stk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  kind_t                   in_kind,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_free,
  output logic                    res_valid,
  output res_t                    res
);

  // memory word: {running minimum, value}
  localparam int WORD_W = 2 * VAL_W;

  state_t                  state;
  state_t                  state_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic signed [VAL_W-1:0] top_val;
  logic signed [VAL_W-1:0] top_val_next;
  logic signed [VAL_W-1:0] top_min;
  logic signed [VAL_W-1:0] top_min_next;

  logic                    in_fire;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [WORD_W-1:0]       rd_data;
  logic [CNT_W-1:0]        count_m2;
  logic signed [VAL_W-1:0] push_min;
  logic                    is_full;

  stk_ram #(
    .DATA_W (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count == CNT_W'(STACK_DEPTH));
  assign count_m2 = count - CNT_W'(2);
  assign push_min = ((count != '0) && (top_min < in_value)) ? top_min : in_value;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (in_kind == KIND_POP) && (count > CNT_W'(1))) begin
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    count_next   = count;
    top_val_next = top_val;
    top_min_next = top_min;
    wr_en        = 1'b0;
    wr_addr      = count[ADDR_W-1:0];
    wr_data      = {push_min, in_value};
    rd_en        = 1'b0;
    rd_addr      = count_m2[ADDR_W-1:0];
    res_valid    = 1'b0;
    res.status   = ST_OK;

    if (state == S_POP_WAIT) begin
      // new top arrives from memory
      top_val_next = rd_data[VAL_W-1:0];
      top_min_next = rd_data[WORD_W-1:VAL_W];
      res_valid    = 1'b1;
    end else if (in_fire) begin
      res_valid = 1'b1;
      unique case (in_kind)
        KIND_PUSH: begin
          if (is_full) begin
            res.status = ST_PUSH_FULL;
          end else begin
            wr_en        = 1'b1;
            top_val_next = in_value;
            top_min_next = push_min;
            count_next   = count + CNT_W'(1);
          end
        end
        KIND_POP: begin
          if (count == '0) begin
            res.status = ST_POP_EMPTY;
          end else begin
            count_next = count - CNT_W'(1);
            if (count > CNT_W'(1)) begin
              // result follows in the next cycle, once the entry below is read
              rd_en     = 1'b1;
              res_valid = 1'b0;
            end
          end
        end
        KIND_CLEAR: begin
          if (count == '0) begin
            res.status = ST_CLEAR_EMPTY;
          end else begin
            count_next = '0;
          end
        end
        KIND_QUERY: begin
        end
        default: begin
        end
      endcase
    end

    res.count     = count_next;
    res.empty_res = (count_next == '0);
    res.top_value = (count_next == '0) ? '0 : top_val_next;
    res.min_value = (count_next == '0) ? '0 : top_min_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // top-of-stack copy
  always_ff @(posedge clk) begin
    top_val <= top_val_next;
    top_min <= top_min_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_wait_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_WAIT) |-> $past(rd_en))
    else $error("pop wait without a memory read");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (in_fire || (state == S_POP_WAIT)))
    else $error("result without an item");

  a_wait_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_WAIT) |-> out_free)
    else $error("output register busy when pop result is ready");

endmodule

[src/stack_with_min_query_unit.sv]
// LIFO stack of up to 256 signed 32-bit values with a constant-time minimum.
// Each transfer on the slave side carries one operation in s_tuser (push,
// pop, clear, query) and the value to push in s_tdata; each produces exactly
// one result transfer with the empty flag, the entry count, the top value,
// the smallest stored value (both zero when empty) and a status code.
// Entries and their running minimum live in one synchronous RAM; the top
// entry is mirrored in registers. Push, clear, query, rejected operations
// and a pop that empties the stack produce their result as the item is
// taken; any other pop produces it in the cycle after, once the RAM's
// registered read has fetched the entry below the top. A result is held
// in an output register; a new item is taken only while that register
// is empty or its result leaves in the same cycle, so a stalled master
// side holds off the slave side. No clearing pass is needed after reset.
module stack_with_min_query_unit
  import stk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0]
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // kind[1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // empty_res, count, top_value, min_value, pad
  output logic [OUT_TUSER_W-1:0] m_tuser    // status[1:0]
);

  logic out_free;
  logic res_valid;
  res_t res;
  res_t out_reg;

  assign out_free = !m_tvalid || m_tready;

  stk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (kind_t'(s_tuser)),
    .in_value  (s_tdata[VAL_W-1:0]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_reg.min_value, out_reg.top_value,
                    out_reg.count, out_reg.empty_res};
  assign m_tuser = out_reg.status;

endmodule
